FILE: rtl/core/gobm_pkg.sv
// Shared widths, codes, types and the tangent boundary table of the orientation band mask.
`timescale 1ns / 1ps
`default_nettype none

package gobm_pkg;

    // Input gradient width and fixed-point precision of the tangent boundaries.
    localparam int GRADIENT_BITS         = 11;
    localparam int TANGENT_FRACTION_BITS = 24;

    // Magnitude of a gradient fits the same width as the signed gradient.
    localparam int MAG_W = GRADIENT_BITS;
    // tan(89 degrees) is below 64, so six integer bits hold every boundary.
    localparam int TAN_W  = TANGENT_FRACTION_BITS + 6;
    localparam int LHS_W  = MAG_W + TANGENT_FRACTION_BITS;
    localparam int PROD_W = TAN_W + MAG_W;

    // Binary search over the degree index: seven steps cover 1..89.
    localparam int SEARCH_STAGES = 7;
    localparam int T_W           = SEARCH_STAGES;
    localparam int TABLE_DEPTH   = 1 << T_W;
    localparam logic [T_W-1:0] LAST_K = T_W'(89);

    // Output angle and configuration widths.
    localparam int DEG_W  = 8;
    localparam int BAND_W = 9;
    localparam logic [DEG_W-1:0] DEG_ZERO     = DEG_W'(0);
    localparam logic [DEG_W-1:0] DEG_RIGHT    = DEG_W'(90);
    localparam logic [DEG_W-1:0] DEG_STRAIGHT = DEG_W'(180);
    localparam logic [DEG_W-1:0] DEG_LAST     = DEG_W'(179);

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 1'b1;
    localparam logic [BAND_W-1:0] BAND_LOW_RST  = BAND_W'(0);
    localparam logic [BAND_W-1:0] BAND_HIGH_RST = BAND_W'(179);

    // One item in flight through the angle search.
    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             x_neg;
        logic             y_neg;
        logic [T_W-1:0]   t;
        logic             eq;
    } t_srch_item;

    typedef logic [TAN_W-1:0] t_tan_table [0:TABLE_DEPTH-1];

    // Q2.62 constants for the series evaluation.
    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q62_DEG = 64'd80489105089745809;

    // Q2.62 product, keeping product bits 125 down to 62.
    function automatic logic [63:0] f_mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // Shift-subtract long division; returns quotient in the upper half, remainder below.
    function automatic logic [127:0] f_divmod64(input logic [63:0] num,
                                                 input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    // Rounded tan(k degrees) at TANGENT_FRACTION_BITS fraction bits, from Taylor series
    // of sine and cosine in Q2.62. Entry zero is zero; entries past 89 are never used.
    function automatic t_tan_table f_build_tan_table();
        t_tan_table   tbl;
        logic [63:0]  x, x2, s, c, ts, tc, q, r, bits, den, bound;
        logic [127:0] dm;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            tbl[k] = '1;
        end
        tbl[0] = '0;
        for (int k = 1; k < 90; k++) begin
            x  = 64'(k) * Q62_DEG;
            x2 = f_mul_q62(x, x);
            s  = x;
            c  = Q62_ONE;
            ts = x;
            tc = Q62_ONE;
            for (int n = 1; n < 24; n++) begin
                den = 64'((2 * n) * (2 * n + 1));
                dm  = f_divmod64(f_mul_q62(ts, x2), den);
                ts  = dm[127:64];
                den = 64'((2 * n - 1) * (2 * n));
                dm  = f_divmod64(f_mul_q62(tc, x2), den);
                tc  = dm[127:64];
                if ((n % 2) == 1) begin
                    s = s - ts;
                    c = c - tc;
                end else begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            if (c == 64'd0) begin
                c = 64'd1;
            end
            dm   = f_divmod64(s, c);
            q    = dm[127:64];
            r    = dm[63:0];
            bits = '0;
            for (int i = 0; i <= TANGENT_FRACTION_BITS; i++) begin
                r    = r << 1;
                bits = bits << 1;
                if (r >= c) begin
                    r    = r - c;
                    bits = bits | 64'd1;
                end
            end
            bound  = ((q << (TANGENT_FRACTION_BITS + 1)) + bits + 64'd1) >> 1;
            tbl[k] = bound[TAN_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_tan_table TAN_BOUND = f_build_tan_table();

endpackage

`default_nettype wire

FILE: rtl/core/gobm_if.sv
// Stream interfaces for gradient words in and orientation words out.
`timescale 1ns / 1ps
`default_nettype none

interface gobm_pix_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [gobm_pkg::GRADIENT_BITS-1:0] horizontal_gradient;
    logic signed [gobm_pkg::GRADIENT_BITS-1:0] vertical_gradient;

    modport source (output valid, output horizontal_gradient, output vertical_gradient,
                    input ready);
    modport sink   (input valid, input horizontal_gradient, input vertical_gradient,
                    output ready);
endinterface

interface gobm_res_if;
    logic                        valid;
    logic                        ready;
    logic [gobm_pkg::DEG_W-1:0]  orientation_degrees;
    logic                        in_band;

    modport source (output valid, output orientation_degrees, output in_band, input ready);
    modport sink   (input valid, input orientation_degrees, input in_band, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gobm_angle_search.sv
// Input capture and pipelined binary search of the first-quadrant angle over the tangent table.
`timescale 1ns / 1ps
`default_nettype none

module gobm_angle_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gobm_pix_if.sink             i_pix,
    output logic                 o_vld,
    output gobm_pkg::t_srch_item o_item,
    input  logic                 i_rdy
);

    localparam int NSTG = gobm_pkg::SEARCH_STAGES + 1;

    logic                 r_vld [0:NSTG-1];
    gobm_pkg::t_srch_item r_stg [0:NSTG-1];
    gobm_pkg::t_srch_item n_stg [0:NSTG-1];
    logic                 stg_en [0:NSTG-1];

    logic [gobm_pkg::T_W-1:0]    cand [1:NSTG-1];
    logic [gobm_pkg::PROD_W-1:0] prod [1:NSTG-1];
    logic [gobm_pkg::PROD_W-1:0] lhs  [1:NSTG-1];
    logic                        take [1:NSTG-1];

    // A stage loads when it is empty or its word moves on.
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_rdy;
        for (int j = NSTG - 2; j >= 0; j--) begin
            stg_en[j] = !r_vld[j] || stg_en[j+1];
        end
    end

    assign i_pix.ready = stg_en[0];

    // Stage zero takes magnitudes and signs of the gradients.
    // Each search stage tries one more bit of the degree index, most significant first.
    // The index is kept when it is at most 89 and ay * 2^F is at least the boundary times
    // ax; the exact-hit flag follows the last index kept.
    always_comb begin
        n_stg[0].x_neg = i_pix.horizontal_gradient[gobm_pkg::GRADIENT_BITS-1];
        n_stg[0].y_neg = i_pix.vertical_gradient[gobm_pkg::GRADIENT_BITS-1];
        n_stg[0].ax    = n_stg[0].x_neg ? (~i_pix.horizontal_gradient + 1'b1)
                                        : i_pix.horizontal_gradient;
        n_stg[0].ay    = n_stg[0].y_neg ? (~i_pix.vertical_gradient + 1'b1)
                                        : i_pix.vertical_gradient;
        n_stg[0].t     = '0;
        n_stg[0].eq    = 1'b0;
        for (int j = 1; j < NSTG; j++) begin
            cand[j] = r_stg[j-1].t | (gobm_pkg::T_W'(1) << (gobm_pkg::SEARCH_STAGES - j));
            prod[j] = gobm_pkg::PROD_W'(gobm_pkg::TAN_BOUND[cand[j]])
                    * gobm_pkg::PROD_W'(r_stg[j-1].ax);
            lhs[j]  = gobm_pkg::PROD_W'({r_stg[j-1].ay,
                                         {gobm_pkg::TANGENT_FRACTION_BITS{1'b0}}});
            take[j] = (cand[j] <= gobm_pkg::LAST_K) && (lhs[j] >= prod[j]);
            n_stg[j] = r_stg[j-1];
            if (take[j]) begin
                n_stg[j].t  = cand[j];
                n_stg[j].eq = (lhs[j] == prod[j]);
            end
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NSTG; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int j = 1; j < NSTG; j++) begin
                if (stg_en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NSTG; j++) begin
            if (stg_en[j]) begin
                r_stg[j] <= n_stg[j];
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_item = r_stg[NSTG-1];

endmodule

`default_nettype wire

FILE: rtl/core/gradient_orientation_band_mask_unit.sv
// Top level of the gradient orientation band mask: angle search, folding, band test.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel's Sobel x and y gradients per word and returns the orientation
// atan2(gy, gx) in whole degrees, truncated toward zero and folded into 0..180, with a
// flag set when that angle lies in the inclusive band [band_low, band_high]. A new word is
// taken every cycle when not stalled; each word passes the input register, seven search
// stages and output register, a depth set by the seven-step binary search of the per-degree
// tangent table, one multiplier and compare per stage. Back-pressure stalls only the stages
// behind a full one, so bubbles are squeezed out. The user must write band bounds through
// the configuration port only while no word is in flight; the block does not enforce it.

module gradient_orientation_band_mask_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gobm_pix_if.sink                       i_pix,
    gobm_res_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [gobm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gobm_pkg::BAND_W-1:0]    i_cfg_data
);

    logic [gobm_pkg::BAND_W-1:0] r_band_low;
    logic [gobm_pkg::BAND_W-1:0] r_band_high;

    logic                 srch_vld;
    logic                 srch_rdy;
    gobm_pkg::t_srch_item srch_item;

    logic                        r_out_vld;
    logic [gobm_pkg::DEG_W-1:0]  r_out_deg;
    logic                        r_out_band;
    logic [gobm_pkg::DEG_W-1:0]  n_out_deg;
    logic                        n_out_band;

    logic [gobm_pkg::DEG_W-1:0]  tq;
    logic                        whole;
    logic [gobm_pkg::DEG_W-1:0]  mag;
    logic signed [gobm_pkg::BAND_W:0] angle_s;
    logic signed [gobm_pkg::BAND_W:0] low_s;
    logic signed [gobm_pkg::BAND_W:0] high_s;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low  <= gobm_pkg::BAND_LOW_RST;
            r_band_high <= gobm_pkg::BAND_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gobm_pkg::CFG_BAND_LOW: begin
                    r_band_low <= i_cfg_data;
                end
                gobm_pkg::CFG_BAND_HIGH: begin
                    r_band_high <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    gobm_angle_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_vld   (srch_vld),
        .o_item  (srch_item),
        .i_rdy   (srch_rdy)
    );

    // The first-quadrant angle becomes a signed angle, folded into 0..180.
    // A vertical gradient with no horizontal part points straight up or down.
    always_comb begin
        if (srch_item.ax == '0) begin
            tq = (srch_item.ay == '0) ? gobm_pkg::DEG_ZERO : gobm_pkg::DEG_RIGHT;
        end else begin
            tq = gobm_pkg::DEG_W'(srch_item.t);
        end
        whole = (srch_item.ax == '0) || (srch_item.ay == '0) || srch_item.eq;
        if (!srch_item.x_neg) begin
            mag = tq;
        end else if (whole) begin
            mag = gobm_pkg::DEG_STRAIGHT - tq;
        end else begin
            mag = gobm_pkg::DEG_LAST - tq;
        end
        if (srch_item.y_neg && (mag != gobm_pkg::DEG_ZERO)) begin
            n_out_deg = gobm_pkg::DEG_STRAIGHT - mag;
        end else begin
            n_out_deg = mag;
        end
    end

    // Inclusive band test against the signed bounds.
    always_comb begin
        angle_s    = $signed({2'b00, n_out_deg});
        low_s      = $signed({r_band_low[gobm_pkg::BAND_W-1], r_band_low});
        high_s     = $signed({r_band_high[gobm_pkg::BAND_W-1], r_band_high});
        n_out_band = (angle_s >= low_s) && (angle_s <= high_s);
    end

    // Output register parts the search from the downstream ready.
    assign srch_rdy = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (srch_rdy) begin
            r_out_vld <= srch_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (srch_rdy) begin
            r_out_deg  <= n_out_deg;
            r_out_band <= n_out_band;
        end
    end

    assign o_res.valid               = r_out_vld;
    assign o_res.orientation_degrees = r_out_deg;
    assign o_res.in_band             = r_out_band;

    // The input side only stalls when every stage is full and the output is held.
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_res.valid && !o_res.ready))
        else $error("input stalled without a held output word");

    // The folded angle never leaves 0..180.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.orientation_degrees <= gobm_pkg::DEG_STRAIGHT))
        else $error("orientation out of range");

    // An empty band never flags a word.
    a_empty_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (srch_rdy && srch_vld && (low_s > high_s)) |=> !o_res.in_band)
        else $error("word flagged with an empty band");

endmodule

`default_nettype wire

FILE: verif/gobm_orientation_checker.sv
// Watches the gradient and orientation channels, predicts each orientation word and compares.
`timescale 1ns / 1ps

module gobm_orientation_checker
    import gobm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gobm_pix_if                  i_pix,
    gobm_res_if                  i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BAND_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int STRAIGHT_DEG = 180;
    localparam int RIGHT_DEG    = 90;
    localparam int LAST_DEG     = 179;

    localparam longint unsigned Q62_UNIT   = 64'h4000_0000_0000_0000;
    localparam longint unsigned Q62_RADIAN = 64'd80489105089745809;

    // One predicted orientation word, with the gradients that produced it.
    typedef struct {
        logic signed [GRADIENT_BITS-1:0] gx;
        logic signed [GRADIENT_BITS-1:0] gy;
        logic [DEG_W-1:0]                degrees;
        logic                            in_band;
    } orient_word_t;

    orient_word_t              expected_orientations [$];
    longint unsigned           tan_limit [0:RIGHT_DEG-1];
    logic signed [BAND_W-1:0]  band_low;
    logic signed [BAND_W-1:0]  band_high;

    // Q2.62 fixed-point product.
    function automatic longint unsigned q62_mul(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // Angle search against the per-degree tangent limits, then folding and band test.
    function automatic orient_word_t predict_orientation(
        input logic signed [GRADIENT_BITS-1:0] gx,
        input logic signed [GRADIENT_BITS-1:0] gy
    );
        orient_word_t    w;
        longint          sx;
        longint          sy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned lhs;
        int              t;
        int              mag;
        int              angle;
        int              lo;
        int              hi;
        bit              whole;
        sx    = gx;
        sy    = gy;
        ax    = (sx < 0) ? -sx : sx;
        ay    = (sy < 0) ? -sy : sy;
        lhs   = ay << TANGENT_FRACTION_BITS;
        t     = 0;
        whole = 1'b1;
        if (ax == 0) begin
            if (ay != 0) begin
                t = RIGHT_DEG;
            end
        end else begin
            for (int k = 1; k < RIGHT_DEG; k++) begin
                if (lhs >= tan_limit[k] * ax) begin
                    t = k;
                end
            end
            whole = (ay == 0) || (t > 0 && lhs == tan_limit[t] * ax);
        end
        // Left half plane mirrors the angle; a fractional angle truncates one lower.
        if (sx >= 0) begin
            mag = t;
        end else if (whole) begin
            mag = STRAIGHT_DEG - t;
        end else begin
            mag = LAST_DEG - t;
        end
        angle = (sy < 0) ? -mag : mag;
        if (angle < 0) begin
            angle = angle + STRAIGHT_DEG;
        end
        lo        = band_low;
        hi        = band_high;
        w.gx      = gx;
        w.gy      = gy;
        w.degrees = DEG_W'(angle);
        w.in_band = (angle >= lo) && (angle <= hi);
        return w;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int due, input int seen);
        $display("[%0t] mismatch, %s: expected %0d, got %0d", $realtime, what, due, seen);
        o_fail_count++;
    endtask

    // Tangent limits from sine and cosine series in Q2.62, rounded to the fraction width.
    initial begin
        longint unsigned x, x2, s, c, ts, tc, q, r, bits;
        tan_limit[0] = 0;
        for (int k = 1; k < RIGHT_DEG; k++) begin
            x  = longint'(k) * Q62_RADIAN;
            x2 = q62_mul(x, x);
            s  = x;
            c  = Q62_UNIT;
            ts = x;
            tc = Q62_UNIT;
            for (int n = 1; n < 24; n++) begin
                ts = q62_mul(ts, x2) / longint'((2 * n) * (2 * n + 1));
                tc = q62_mul(tc, x2) / longint'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    s = s - ts;
                    c = c - tc;
                end else begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            if (c == 0) begin
                c = 1;
            end
            q    = s / c;
            r    = s % c;
            bits = 0;
            for (int i = 0; i <= TANGENT_FRACTION_BITS; i++) begin
                r    = r << 1;
                bits = bits << 1;
                if (r >= c) begin
                    r    = r - c;
                    bits = bits | 1;
                end
            end
            tan_limit[k] = ((q << (TANGENT_FRACTION_BITS + 1)) + bits + 1) >> 1;
        end
    end

    // Results are checked before the new word is predicted, so an empty store is caught.
    always @(posedge i_clk) begin
        orient_word_t due;
        if (!i_rst_n) begin
            expected_orientations.delete();
            band_low     = BAND_LOW_RST;
            band_high    = BAND_HIGH_RST;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_orientations.size() == 0) begin
                    report_mismatch("orientation word with nothing due", 0,
                                    i_res.orientation_degrees);
                end else begin
                    due = expected_orientations.pop_front();
                    o_checked++;
                    if (i_res.orientation_degrees !== due.degrees) begin
                        report_mismatch($sformatf("degrees for gx=%0d gy=%0d", due.gx, due.gy),
                                        due.degrees, i_res.orientation_degrees);
                    end
                    if (i_res.in_band !== due.in_band) begin
                        report_mismatch($sformatf("in_band for gx=%0d gy=%0d", due.gx, due.gy),
                                        due.in_band, i_res.in_band);
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_orientations.push_back(
                    predict_orientation(i_pix.horizontal_gradient, i_pix.vertical_gradient));
            end
            // Bounds change only while nothing is in flight.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BAND_LOW: begin
                        band_low = i_cfg_data;
                    end
                    CFG_BAND_HIGH: begin
                        band_high = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_orientations.size();
    end

endmodule

FILE: verif/tb_gradient_orientation_band_mask_unit.sv
// Stimulus and verdict for the gradient orientation band mask unit.
`timescale 1ns / 1ps

module tb_gradient_orientation_band_mask_unit;
    import gobm_pkg::*;

    localparam int CLK_PERIOD         = 10;
    localparam int RESET_CYCLES       = 7;
    localparam int DRAIN_CYCLES       = 20;
    localparam int HOLD_CYCLES        = 300;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int RANDOM_PER_SETTING = 84;
    localparam int NUM_SETTINGS       = 9;
    localparam int NUM_DIRECTED       = 24;

    // Axes, diagonals, full-scale corners and near-axis fractional angles.
    localparam int DIR_GX [NUM_DIRECTED] = '{0, -5, 5, 0, 0, 5, -5, -5, 5, -7, 1023, -1024,
                                             -1024, 1023, -1024, 0, 1023, -1024, 100, 1020,
                                             -1020, 1, -1, 3};
    localparam int DIR_GY [NUM_DIRECTED] = '{0, 0, 0, 5, -5, 5, 5, -5, -5, 3, 1023, -1024,
                                             1023, -1024, 0, -1024, 0, -1, -1, -1020,
                                             1020, 1023, -1024, -7};

    // Band settings: nominal, narrow, single degree, inverted and full-width extremes.
    localparam int BAND_LO_SET [NUM_SETTINGS] = '{-179, 0, 90, 45, 120, -256, 255, 180, 0};
    localparam int BAND_HI_SET [NUM_SETTINGS] = '{179, 90, 180, 45, 30, 255, -256, 180, 0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BAND_W-1:0]    i_cfg_data;

    int src_idle_pct  = 29;
    int sink_idle_pct = 73;
    int hold_left     = 0;
    int cycle_count   = 0;
    int fail_count;
    int pending;
    int checked;

    gobm_pix_if pix_if ();
    gobm_res_if res_if ();

    gradient_orientation_band_mask_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    gobm_orientation_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_gradient_orientation_band_mask_unit NOT OK");
            $finish;
        end
    end

    // Orientation sink: random stalls, or a long hold-off while hold_left counts down.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offers one gradient word after random gaps and holds it until it is taken.
    task automatic send_gradient(input logic [GRADIENT_BITS-1:0] gx,
                                 input logic [GRADIENT_BITS-1:0] gy);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid               = 1'b1;
        pix_if.horizontal_gradient = gx;
        pix_if.vertical_gradient   = gy;
        do begin
            @(posedge i_clk);
        end while (!pix_if.ready);
        @(negedge i_clk);
        pix_if.valid = 1'b0;
    endtask

    // Holds the source off until every predicted word has come back.
    task automatic wait_for_results();
        pix_if.valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_band(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = BAND_W'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    initial begin
        logic [GRADIENT_BITS-1:0] gx;
        logic [GRADIENT_BITS-1:0] gy;
        logic [GRADIENT_BITS-1:0] swap;
        int                       sel;
        int                       base;
        int                       mult;
        i_rst_n                    = 1'b0;
        i_cfg_we                   = 1'b0;
        i_cfg_idx                  = CFG_BAND_LOW;
        i_cfg_data                 = '0;
        pix_if.valid               = 1'b0;
        pix_if.horizontal_gradient = '0;
        pix_if.vertical_gradient   = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words against the reset band.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_gradient(GRADIENT_BITS'(DIR_GX[i]), GRADIENT_BITS'(DIR_GY[i]));
        end

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            wait_for_results();
            write_band(CFG_BAND_LOW, BAND_LO_SET[s]);
            write_band(CFG_BAND_HIGH, BAND_HI_SET[s]);
            if (s < 3) begin
                src_idle_pct  = 29;
                sink_idle_pct = 73;
            end else if (s < 6) begin
                src_idle_pct  = 73;
                sink_idle_pct = 29;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                // Long sink hold-off while the source keeps offering, so the pipe fills.
                if (s == 1 && n == 10) begin
                    hold_left = HOLD_CYCLES;
                end
                if (s == 4 && n == 40) begin
                    wait_for_results();
                end
                sel = $urandom_range(99);
                if (sel < 55) begin
                    gx = GRADIENT_BITS'($urandom);
                    gy = GRADIENT_BITS'($urandom);
                end else if (sel < 75) begin
                    gx = GRADIENT_BITS'($urandom_range(16)) - GRADIENT_BITS'(8);
                    gy = GRADIENT_BITS'($urandom_range(16)) - GRADIENT_BITS'(8);
                end else begin
                    // Exact ratios: axes, diagonals and integer slopes of two and three.
                    base = $urandom_range(255, 1);
                    mult = $urandom_range(3);
                    gx   = GRADIENT_BITS'(base);
                    gy   = GRADIENT_BITS'(base * mult);
                    if ($urandom_range(1)) begin
                        swap = gx;
                        gx   = gy;
                        gy   = swap;
                    end
                    if ($urandom_range(1)) begin
                        gx = -gx;
                    end
                    if ($urandom_range(1)) begin
                        gy = -gy;
                    end
                end
                send_gradient(gx, gy);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Summary: %0d orientation words checked, reset band and %0d written bands,",
                 checked, NUM_SETTINGS);
        $display("Summary: inverted and wide bounds, source gaps, sink stalls, a long hold-off.");
        if (fail_count == 0) begin
            $display("tb_gradient_orientation_band_mask_unit OK");
        end else begin
            $display("tb_gradient_orientation_band_mask_unit NOT OK");
        end
        $finish;
    end

endmodule

FILE: gradient_orientation_band_mask_unit.f
rtl/core/gobm_pkg.sv
rtl/core/gobm_if.sv
rtl/core/gobm_angle_search.sv
rtl/core/gradient_orientation_band_mask_unit.sv
verif/gobm_orientation_checker.sv
verif/tb_gradient_orientation_band_mask_unit.sv
